/* sv/scgn_pkg.sv */
// shared types and constants for the structured grid ngon connectivity unit
`timescale 1ns / 1ps
package scgn_pkg;

    localparam int DEF_MAX_DIM = 256;
    localparam int SIZE_W      = 9;
    localparam int VAL_W       = 28;
    localparam int CNT_W       = 3;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int LIM_W       = SIZE_W + 1;
    localparam int TDATA_W     = ((CNT_W + 6 * VAL_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_I = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_J = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_K = 2'd2;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_FACE1  = 3'd1;
    localparam logic [2:0] PH_FACE2  = 3'd2;
    localparam logic [2:0] PH_FACE3  = 3'd3;
    localparam logic [2:0] PH_ELEM   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_1D   = 2'd1;
    localparam logic [1:0] MODE_2D   = 2'd2;
    localparam logic [1:0] MODE_3D   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FACE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ELEM   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic mul1;
        logic mul2;
        logic sum;
        logic emit;
    } scgn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_pending;
        logic out_free;
    } scgn_stat_t;

endpackage

/* sv/scgn_ctrl.sv */
// request sequencer for the connectivity unit
`timescale 1ns / 1ps
module scgn_ctrl import scgn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       req_valid,
    input  logic       req_restart,
    output logic       req_ready,
    input  scgn_stat_t stat,
    output scgn_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LAT  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    state_next = (req_restart || stat.hdr_pending) ? S_LAT : S_EMIT;
                end
            end
            S_LAT: begin
                cmd.latch  = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* sv/scgn_dp.sv */
// sizes, header arithmetic, loop counters, index generation and result register
`timescale 1ns / 1ps
module scgn_dp import scgn_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [SIZE_W-1:0]    cfg_val,
    input  scgn_cmd_t            cmd,
    output scgn_stat_t           stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    out_kind,
    output logic [CNT_W-1:0]     out_cnt,
    output logic [6*VAL_W-1:0]   out_vals,
    output logic                 out_last
);

    localparam int CMP_W = 12;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DIM);

    logic [SIZE_W-1:0] size_i_reg, size_j_reg, size_k_reg;
    logic [2:0]        phase_reg, phase_next;
    logic [1:0]        mode_reg;
    logic [SIZE_W-1:0] lat_i_reg, lat_j_reg, lat_k_reg;
    logic [SIZE_W-1:0] li1_reg, lj1_reg, lk1_reg, a_reg, b_reg;
    logic [VAL_W-1:0]  pl_reg, q_inj1_reg, q_i1j_reg, q_i1j1_reg, lq_reg, c2i_reg, c2j_reg;
    logic [VAL_W-1:0]  nc_reg, cif_reg, cjf_reg, third_reg, nf_reg;
    logic [SIZE_W-1:0] i_reg, j_reg, k_reg;
    logic [VAL_W-1:0]  jkx_reg, kx_reg, jky_reg, ky_reg, jkz_reg, kz_reg;
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [6*VAL_W-1:0] vals_reg;
    logic              last_reg;

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) r = SIZE_W'(1);
        else if (CMP_W'(v) > MAX_C) r = MAX_C[SIZE_W-1:0];
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] less1(input logic [SIZE_W-1:0] v);
        return (v > SIZE_W'(1)) ? v - SIZE_W'(1) : SIZE_W'(1);
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_i_reg <= SIZE_W'(1);
            size_j_reg <= SIZE_W'(1);
            size_k_reg <= SIZE_W'(1);
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_SIZE_I: size_i_reg <= cfg_val;
                REG_SIZE_J: size_j_reg <= cfg_val;
                REG_SIZE_K: size_k_reg <= cfg_val;
                default: ;
            endcase
        end
    end

    // stage 1: latch sizes, pick mode
    logic [SIZE_W-1:0] ci, cj, ck;
    logic              oi, oj, ok;
    logic [1:0]        ones;
    always_comb begin
        ci   = clamp_dim(size_i_reg);
        cj   = clamp_dim(size_j_reg);
        ck   = clamp_dim(size_k_reg);
        oi   = (ci == SIZE_W'(1));
        oj   = (cj == SIZE_W'(1));
        ok   = (ck == SIZE_W'(1));
        ones = 2'(oi) + 2'(oj) + 2'(ok);
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            lat_i_reg <= ci;
            lat_j_reg <= cj;
            lat_k_reg <= ck;
            li1_reg   <= less1(ci);
            lj1_reg   <= less1(cj);
            lk1_reg   <= less1(ck);
            if (ones >= 2'd2) begin
                a_reg <= (oj && ok) ? ci : ((oi && ok) ? cj : ck);
                b_reg <= SIZE_W'(1);
            end else if (ok) begin
                a_reg <= ci;
                b_reg <= cj;
            end else if (oj) begin
                a_reg <= ci;
                b_reg <= ck;
            end else begin
                a_reg <= ones == 2'd0 ? ci : cj;
                b_reg <= ones == 2'd0 ? cj : ck;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NONE;
        end else if (cmd.latch) begin
            mode_reg <= (ones >= 2'd2) ? MODE_1D : ((ones == 2'd1) ? MODE_2D : MODE_3D);
        end
    end

    // stage 2: pairwise products
    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            pl_reg     <= VAL_W'(lat_i_reg) * VAL_W'(lat_j_reg);
            q_inj1_reg <= VAL_W'(lat_i_reg) * VAL_W'(lj1_reg);
            q_i1j_reg  <= VAL_W'(li1_reg) * VAL_W'(lat_j_reg);
            q_i1j1_reg <= VAL_W'(li1_reg) * VAL_W'(lj1_reg);
            lq_reg     <= VAL_W'(li1_reg) * VAL_W'(lj1_reg);
            c2i_reg    <= VAL_W'(a_reg) * VAL_W'(b_reg - SIZE_W'(1));
            c2j_reg    <= VAL_W'(a_reg - SIZE_W'(1)) * VAL_W'(b_reg);
        end
    end

    // stage 3: triple products, face counts per direction
    always_ff @(posedge aclk) begin
        if (cmd.mul2) begin
            nc_reg    <= lq_reg * VAL_W'(lk1_reg);
            third_reg <= q_i1j1_reg * VAL_W'(lat_k_reg);
            case (mode_reg)
                MODE_1D: begin
                    cif_reg <= VAL_W'(a_reg);
                    cjf_reg <= '0;
                end
                MODE_2D: begin
                    cif_reg <= c2i_reg;
                    cjf_reg <= c2j_reg;
                end
                default: begin
                    cif_reg <= q_inj1_reg * VAL_W'(lk1_reg);
                    cjf_reg <= q_i1j_reg * VAL_W'(lk1_reg);
                end
            endcase
        end
    end

    // stage 4: face total
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            case (mode_reg)
                MODE_1D: nf_reg <= cif_reg;
                MODE_2D: nf_reg <= cif_reg + cjf_reg;
                default: nf_reg <= cif_reg + cjf_reg + third_reg;
            endcase
        end
    end

    // loop limits of the current phase
    logic [LIM_W-1:0] lim_i, lim_j, lim_k;
    always_comb begin
        lim_i = LIM_W'(1);
        lim_j = LIM_W'(1);
        lim_k = LIM_W'(1);
        case (mode_reg)
            MODE_1D: begin
                lim_i = (phase_reg == PH_ELEM) ? LIM_W'(less1(a_reg)) : LIM_W'(a_reg);
            end
            MODE_2D: begin
                lim_i = (phase_reg == PH_FACE1) ? LIM_W'(a_reg) : LIM_W'(a_reg) - LIM_W'(1);
                lim_j = (phase_reg == PH_FACE2) ? LIM_W'(b_reg) : LIM_W'(b_reg) - LIM_W'(1);
            end
            default: begin
                lim_i = (phase_reg == PH_FACE1) ? LIM_W'(lat_i_reg)
                                                : LIM_W'(lat_i_reg) - LIM_W'(1);
                lim_j = (phase_reg == PH_FACE2) ? LIM_W'(lat_j_reg)
                                                : LIM_W'(lat_j_reg) - LIM_W'(1);
                lim_k = (phase_reg == PH_FACE3) ? LIM_W'(lat_k_reg)
                                                : LIM_W'(lat_k_reg) - LIM_W'(1);
            end
        endcase
    end

    // row and plane strides of the three running bases
    logic [VAL_W-1:0] sjx, skx, sjy, sky, sjz, skz;
    always_comb begin
        sjx = (mode_reg == MODE_2D) ? VAL_W'(a_reg) : VAL_W'(lat_i_reg);
        skx = (phase_reg == PH_ELEM) ? q_inj1_reg : pl_reg;
        sjy = (mode_reg == MODE_2D) ? VAL_W'(a_reg - SIZE_W'(1)) : VAL_W'(li1_reg);
        sky = q_i1j_reg;
        sjz = VAL_W'(li1_reg);
        skz = q_i1j1_reg;
    end

    logic is_hdr, is_done, wrap_i, wrap_j, wrap_k;
    always_comb begin
        is_hdr  = (phase_reg == PH_HEADER);
        is_done = (phase_reg == PH_DONE);
        wrap_i  = !(LIM_W'(i_reg) + LIM_W'(1) < lim_i);
        wrap_j  = !(LIM_W'(j_reg) + LIM_W'(1) < lim_j);
        wrap_k  = !(LIM_W'(k_reg) + LIM_W'(1) < lim_k);
    end

    // index generation
    logic [VAL_W-1:0] iv, n1, b1, f3, f5, fn, ef;
    logic [VAL_W-1:0] v0, v1, v2, v3, v4, v5;
    logic [CNT_W-1:0] cnt;
    logic [KIND_W-1:0] kind;
    logic              fin;
    always_comb begin
        iv  = VAL_W'(i_reg);
        n1  = iv + jkx_reg;
        b1  = n1;
        f3  = cif_reg + iv + jky_reg;
        f5  = cif_reg + cjf_reg + iv + jkz_reg;
        v0  = '0; v1 = '0; v2 = '0; v3 = '0; v4 = '0; v5 = '0;
        cnt = '0;
        fn  = '0;
        ef  = '0;
        case (mode_reg)
            MODE_1D: begin
                fn = nf_reg << 1;
                ef = (nc_reg << 1) + nc_reg;
            end
            MODE_2D: begin
                fn = (nf_reg << 1) + nf_reg;
                ef = (nc_reg << 2) + nc_reg;
            end
            default: begin
                fn = (nf_reg << 2) + nf_reg;
                ef = (nc_reg << 3) - nc_reg;
            end
        endcase
        if (is_hdr) begin
            kind = KIND_HEADER;
            cnt  = CNT_W'(4);
            v0 = nf_reg; v1 = fn; v2 = nc_reg; v3 = ef;
        end else if (is_done) begin
            kind = KIND_DONE;
        end else begin
            kind = (phase_reg == PH_ELEM) ? KIND_ELEM : KIND_FACE;
            case (mode_reg)
                MODE_1D: begin
                    v0 = iv + VAL_W'(1);
                    if (phase_reg == PH_FACE1) begin
                        cnt = CNT_W'(1);
                    end else begin
                        cnt = CNT_W'(2);
                        v1  = iv + VAL_W'(2);
                    end
                end
                MODE_2D: begin
                    if (phase_reg == PH_FACE1) begin
                        cnt = CNT_W'(2);
                        v0 = b1 + VAL_W'(1); v1 = b1 + VAL_W'(a_reg) + VAL_W'(1);
                    end else if (phase_reg == PH_FACE2) begin
                        cnt = CNT_W'(2);
                        v0 = b1 + VAL_W'(1); v1 = b1 + VAL_W'(2);
                    end else begin
                        cnt = CNT_W'(4);
                        v0 = b1 + VAL_W'(1); v1 = f3 + VAL_W'(1);
                        v2 = b1 + VAL_W'(2); v3 = f3 + VAL_W'(a_reg);
                    end
                end
                default: begin
                    if (phase_reg == PH_FACE1) begin
                        cnt = CNT_W'(4);
                        v0 = n1 + VAL_W'(1);
                        v1 = n1 + VAL_W'(lat_i_reg) + VAL_W'(1);
                        v2 = n1 + VAL_W'(lat_i_reg) + pl_reg + VAL_W'(1);
                        v3 = n1 + pl_reg + VAL_W'(1);
                    end else if (phase_reg == PH_FACE2) begin
                        cnt = CNT_W'(4);
                        v0 = n1 + VAL_W'(1);
                        v1 = n1 + VAL_W'(2);
                        v2 = n1 + pl_reg + VAL_W'(2);
                        v3 = n1 + pl_reg + VAL_W'(1);
                    end else if (phase_reg == PH_FACE3) begin
                        cnt = CNT_W'(4);
                        v0 = n1 + VAL_W'(1);
                        v1 = n1 + VAL_W'(2);
                        v2 = n1 + VAL_W'(lat_i_reg) + VAL_W'(2);
                        v3 = n1 + VAL_W'(lat_i_reg) + VAL_W'(1);
                    end else begin
                        cnt = CNT_W'(6);
                        v0 = n1 + VAL_W'(1);
                        v1 = n1 + VAL_W'(2);
                        v2 = f3 + VAL_W'(1);
                        v3 = f3 + VAL_W'(li1_reg) + VAL_W'(1);
                        v4 = f5 + VAL_W'(1);
                        v5 = f5 + q_i1j1_reg + VAL_W'(1);
                    end
                end
            endcase
        end
        fin = wrap_i && wrap_j && wrap_k;
        phase_next = phase_reg;
        if (is_hdr) begin
            phase_next = PH_FACE1;
        end else if (!is_done && fin) begin
            if (phase_reg == PH_ELEM) begin
                phase_next = PH_DONE;
            end else if (phase_reg == PH_FACE3 || mode_reg == MODE_1D
                         || (phase_reg == PH_FACE2 && mode_reg != MODE_3D)) begin
                phase_next = PH_ELEM;
            end else begin
                phase_next = phase_reg + 3'd1;
            end
        end
    end

    // phase and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
            jkx_reg <= '0; kx_reg <= '0; jky_reg <= '0;
            ky_reg <= '0; jkz_reg <= '0; kz_reg <= '0;
        end else if (cmd.latch) begin
            phase_reg <= PH_HEADER;
        end else if (cmd.emit) begin
            phase_reg <= phase_next;
            if (is_hdr || (!is_done && fin)) begin
                i_reg <= '0; j_reg <= '0; k_reg <= '0;
                jkx_reg <= '0; kx_reg <= '0; jky_reg <= '0;
                ky_reg <= '0; jkz_reg <= '0; kz_reg <= '0;
            end else if (!is_done) begin
                if (!wrap_i) begin
                    i_reg <= i_reg + SIZE_W'(1);
                end else if (!wrap_j) begin
                    i_reg   <= '0;
                    j_reg   <= j_reg + SIZE_W'(1);
                    jkx_reg <= jkx_reg + sjx;
                    jky_reg <= jky_reg + sjy;
                    jkz_reg <= jkz_reg + sjz;
                end else begin
                    i_reg   <= '0;
                    j_reg   <= '0;
                    k_reg   <= k_reg + SIZE_W'(1);
                    kx_reg  <= kx_reg + skx;
                    ky_reg  <= ky_reg + sky;
                    kz_reg  <= kz_reg + skz;
                    jkx_reg <= kx_reg + skx;
                    jky_reg <= ky_reg + sky;
                    jkz_reg <= kz_reg + skz;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg <= kind;
            cnt_reg  <= cnt;
            vals_reg <= {v5, v4, v3, v2, v1, v0};
            last_reg <= !is_hdr && !is_done && fin && (phase_reg == PH_ELEM);
        end
    end

    assign stat.hdr_pending = is_hdr;
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_cnt   = cnt_reg;
    assign out_vals  = vals_reg;
    assign out_last  = last_reg;

endmodule

/* sv/structured_grid_ngon_connectivity_unit.sv */
// top level of the structured grid ngon connectivity unit
`timescale 1ns / 1ps
// Streams the NGON connectivity of a structured grid of size_i x size_j x size_k
// points, one record per request item. A request with restart set (or the first
// request after reset) latches the sizes, picks 1D, 2D or 3D and returns the
// header; later requests return face records, then element records, the final
// element record flagged on m_tlast, then done records. A header result passes
// through the sizes latch, two multiply stages, the face sum and the output
// register, and a header request holds the sequencer until that result is emitted;
// any other result goes from acceptance straight to the output step, and the next
// request can be taken once that result has been emitted, since the loop
// counters and running row/plane bases produce one record per pass through the
// sequencer. A result that waits on the output register stalls the sequencer
// only at its output step.
// The next request is taken while a result still waits on the output register.
// Size registers must be written by the user through the cfg port only while
// the unit is idle (the unit does not enforce this); they take effect at the next header.
module structured_grid_ngon_connectivity_unit import scgn_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    // request items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] restart
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // entry_count, value_a .. value_f, zero pad
    output logic [KIND_W-1:0]    m_tuser,   // kind
    output logic                 m_tlast
);

    scgn_cmd_t           cmd;
    scgn_stat_t          stat;
    logic [CNT_W-1:0]    cnt;
    logic [6*VAL_W-1:0]  vals;

    // config is always accepted
    assign cfg_ready = 1'b1;

    scgn_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_restart (s_tdata[0]),
        .req_ready   (s_tready),
        .stat        (stat),
        .cmd         (cmd)
    );

    scgn_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_cnt   (cnt),
        .out_vals  (vals),
        .out_last  (m_tlast)
    );

    // pack result payload, count in the low bits
    assign m_tdata = {{(TDATA_W - CNT_W - 6 * VAL_W){1'b0}}, vals, cnt};

endmodule

/* sim/tb.sv */
// testbench for the structured grid ngon connectivity unit
`timescale 1ns / 1ps
// Drives request items (mostly "next", some restarts) through the connectivity unit over a
// range of grid sizes and 1D/2D/3D shapes. A local record generator tracks the sequencer
// state and predicts every result record, which the monitor compares field by field.
module tb import scgn_pkg::*;;

    localparam int LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  cnt;
        logic [VAL_W-1:0]  va, vb, vc, vd, ve, vf;
        logic              last;
    } rec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic m_tlast;

    structured_grid_ngon_connectivity_unit u_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // generator state
    int unsigned sz_i = 1, sz_j = 1, sz_k = 1;
    int unsigned g_phase = PH_HEADER, g_mode = 0;
    int unsigned li_cnt = 0, lj_cnt = 0, lk_cnt = 0;
    longint unsigned fi_cnt = 0, fj_cnt = 0, plane = 0;
    int unsigned lat_i = 1, lat_j = 1, lat_k = 1, ax_a = 1, ax_b = 1;

    bit [7:0] req_q[$];
    rec_t     record_q[$];
    int       errors = 0;
    int       n_req = 0, n_res = 0, n_last = 0;
    longint   cycles = 0;
    bit       quiet_tail = 0;
    int       s_gap = 0, m_stall = 0;

    function automatic int unsigned clamp_size(int unsigned v);
        if (v == 0) return 1;
        if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned minus1(int unsigned v);
        return (v > 1) ? v - 1 : 1;
    endfunction

    // one request item in, one predicted record out
    function automatic rec_t next_record(bit restart);
        rec_t r;
        longint unsigned v[6];
        longint unsigned ni, nj, nk, ni1, nj1, nk1, nc, nf;
        longint unsigned i, j, k, b1, f1, f3, f5;
        int unsigned lim_i, lim_j, lim_k;
        bit wrapped;
        r = '0;
        foreach (v[n]) v[n] = 0;
        if (restart) g_phase = PH_HEADER;
        if (g_phase == PH_HEADER) begin
            li_cnt = 0; lj_cnt = 0; lk_cnt = 0;
            lat_i = clamp_size(sz_i); lat_j = clamp_size(sz_j); lat_k = clamp_size(sz_k);
            ni = lat_i; nj = lat_j; nk = lat_k;
            ni1 = minus1(lat_i); nj1 = minus1(lat_j); nk1 = minus1(lat_k);
            nc = ni1 * nj1 * nk1;
            plane = ni * nj;
            if (int'(ni == 1) + int'(nj == 1) + int'(nk == 1) >= 2) begin
                g_mode = 1;
                ax_a = (nj == 1 && nk == 1) ? lat_i : (ni == 1 && nk == 1) ? lat_j : lat_k;
                ax_b = 1;
                fi_cnt = ax_a; fj_cnt = 0;
                nf = ni * nj * nk;
                v[1] = 2 * nf; v[3] = 3 * nc;
            end else if (ni == 1 || nj == 1 || nk == 1) begin
                g_mode = 2;
                if (nk == 1) begin ax_a = lat_i; ax_b = lat_j; end
                else if (nj == 1) begin ax_a = lat_i; ax_b = lat_k; end
                else begin ax_a = lat_j; ax_b = lat_k; end
                fi_cnt = ax_a * (ax_b - 1);
                fj_cnt = (ax_a - 1) * ax_b;
                nf = fi_cnt + fj_cnt;
                v[1] = 3 * nf; v[3] = 5 * nc;
            end else begin
                g_mode = 3;
                ax_a = lat_i; ax_b = lat_j;
                fi_cnt = ni * nj1 * nk1;
                fj_cnt = ni1 * nj * nk1;
                nf = fi_cnt + fj_cnt + ni1 * nj1 * nk;
                v[1] = 5 * nf; v[3] = 7 * nc;
            end
            v[0] = nf; v[2] = nc;
            r.kind = KIND_HEADER; r.cnt = CNT_W'(4);
            g_phase = PH_FACE1;
        end else if (g_phase == PH_DONE) begin
            r.kind = KIND_DONE;
        end else begin
            r.kind = (g_phase == PH_ELEM) ? KIND_ELEM : KIND_FACE;
            i = li_cnt; j = lj_cnt; k = lk_cnt;
            if (g_mode == 1) begin
                v[0] = i + 1;
                if (g_phase == PH_FACE1) r.cnt = CNT_W'(1);
                else begin v[1] = i + 2; r.cnt = CNT_W'(2); end
            end else if (g_mode == 2) begin
                b1 = i + j * ax_a;
                r.cnt = CNT_W'(2);
                if (g_phase == PH_FACE1) begin v[0] = b1 + 1; v[1] = b1 + ax_a + 1; end
                else if (g_phase == PH_FACE2) begin v[0] = b1 + 1; v[1] = b1 + 2; end
                else begin
                    f3 = fi_cnt + i + j * (ax_a - 1);
                    v[0] = b1 + 1; v[1] = f3 + 1; v[2] = b1 + 2; v[3] = f3 + ax_a;
                    r.cnt = CNT_W'(4);
                end
            end else begin
                ni = lat_i; nj = lat_j; ni1 = lat_i - 1; nj1 = lat_j - 1;
                b1 = i + j * ni + k * plane;
                r.cnt = CNT_W'(4);
                case (g_phase)
                    PH_FACE1: begin
                        v[0] = b1 + 1; v[1] = b1 + ni + 1; v[2] = b1 + ni + plane + 1;
                        v[3] = b1 + plane + 1;
                    end
                    PH_FACE2: begin
                        v[0] = b1 + 1; v[1] = b1 + 2; v[2] = b1 + plane + 2;
                        v[3] = b1 + plane + 1;
                    end
                    PH_FACE3: begin
                        v[0] = b1 + 1; v[1] = b1 + 2; v[2] = b1 + ni + 2; v[3] = b1 + ni + 1;
                    end
                    default: begin
                        f1 = i + j * ni + k * ni * nj1;
                        f3 = fi_cnt + i + j * ni1 + k * ni1 * nj;
                        f5 = fi_cnt + fj_cnt + i + j * ni1 + k * ni1 * nj1;
                        v[0] = f1 + 1; v[1] = f1 + 2; v[2] = f3 + 1; v[3] = f3 + ni1 + 1;
                        v[4] = f5 + 1; v[5] = f5 + ni1 * nj1 + 1;
                        r.cnt = CNT_W'(6);
                    end
                endcase
            end
            // loop limits for this phase
            lim_i = 1; lim_j = 1; lim_k = 1;
            if (g_mode == 1) lim_i = (g_phase == PH_ELEM) ? minus1(ax_a) : ax_a;
            else if (g_mode == 2) begin
                lim_i = (g_phase == PH_FACE1) ? ax_a : ax_a - 1;
                lim_j = (g_phase == PH_FACE2) ? ax_b : ax_b - 1;
            end else begin
                lim_i = (g_phase == PH_FACE1) ? lat_i : lat_i - 1;
                lim_j = (g_phase == PH_FACE2) ? lat_j : lat_j - 1;
                lim_k = (g_phase == PH_FACE3) ? lat_k : lat_k - 1;
            end
            wrapped = 0;
            li_cnt++;
            if (li_cnt >= lim_i) begin
                li_cnt = 0; lj_cnt++;
                if (lj_cnt >= lim_j) begin
                    lj_cnt = 0; lk_cnt++;
                    if (lk_cnt >= lim_k) begin lk_cnt = 0; wrapped = 1; end
                end
            end
            if (wrapped) begin
                if (g_phase == PH_ELEM) begin g_phase = PH_DONE; r.last = 1'b1; end
                else if (g_phase == PH_FACE3 || (g_phase == PH_FACE2 && g_mode != 3)
                         || g_mode == 1)
                    g_phase = PH_ELEM;
                else g_phase++;
            end
        end
        r.va = v[0][VAL_W-1:0]; r.vb = v[1][VAL_W-1:0]; r.vc = v[2][VAL_W-1:0];
        r.vd = v[3][VAL_W-1:0]; r.ve = v[4][VAL_W-1:0]; r.vf = v[5][VAL_W-1:0];
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                record_q.push_back(next_record(s_tdata[0]));
                n_req++;
            end
            if (s_gap > 0 && !(s_tvalid && !s_tready)) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!s_tvalid || s_tready) begin
                if (req_q.size() > 0) begin
                    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                        s_gap <= $urandom_range(1, 12) - 1;
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata <= req_q.pop_front();
                    end
                end else s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge aclk) begin
        rec_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser; got.cnt = m_tdata[CNT_W-1:0];
                got.va = m_tdata[CNT_W +: VAL_W];
                got.vb = m_tdata[CNT_W + VAL_W +: VAL_W];
                got.vc = m_tdata[CNT_W + 2*VAL_W +: VAL_W];
                got.vd = m_tdata[CNT_W + 3*VAL_W +: VAL_W];
                got.ve = m_tdata[CNT_W + 4*VAL_W +: VAL_W];
                got.vf = m_tdata[CNT_W + 5*VAL_W +: VAL_W];
                got.last = m_tlast;
                n_res++;
                if (record_q.size() == 0) begin
                    $error("unexpected record kind=%0d", got.kind);
                    errors++;
                end else begin
                    want = record_q.pop_front();
                    if (got.last) n_last++;
                    if (got.kind !== want.kind) begin
                        $error("kind exp %0d got %0d", want.kind, got.kind); errors++; end
                    if (got.cnt !== want.cnt) begin
                        $error("entry_count exp %0d got %0d", want.cnt, got.cnt); errors++; end
                    if (got.va !== want.va) begin
                        $error("value_a exp %0d got %0d", want.va, got.va); errors++; end
                    if (got.vb !== want.vb) begin
                        $error("value_b exp %0d got %0d", want.vb, got.vb); errors++; end
                    if (got.vc !== want.vc) begin
                        $error("value_c exp %0d got %0d", want.vc, got.vc); errors++; end
                    if (got.vd !== want.vd) begin
                        $error("value_d exp %0d got %0d", want.vd, got.vd); errors++; end
                    if (got.ve !== want.ve) begin
                        $error("value_e exp %0d got %0d", want.ve, got.ve); errors++; end
                    if (got.vf !== want.vf) begin
                        $error("value_f exp %0d got %0d", want.vf, got.vf); errors++; end
                    if (got.last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last); errors++; end
                end
            end
            if (m_stall > 0) begin
                m_stall <= m_stall - 1;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                m_stall <= $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (req_q.size() > 0 || s_tvalid || record_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_index <= idx;
        cfg_data <= val[SIZE_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        // ignored indexes leave the sizes untouched
        case (idx)
            REG_SIZE_I: sz_i = val[SIZE_W-1:0];
            REG_SIZE_J: sz_j = val[SIZE_W-1:0];
            REG_SIZE_K: sz_k = val[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(int unsigned a, int unsigned b, int unsigned c);
        write_size(REG_SIZE_I, a);
        write_size(REG_SIZE_J, b);
        write_size(REG_SIZE_K, c);
        @(posedge aclk);
    endtask

    // one stream: a restart request, then n_next next requests
    task automatic queue_stream(int unsigned n_next);
        req_q.push_back(8'h01);
        repeat (n_next) req_q.push_back({7'($urandom_range(0, 127)), 1'b0});
    endtask

    int unsigned a, b, c, n_rec;

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default all-ones grid, first request without restart
        req_q.push_back(8'hFE);
        repeat (3) req_q.push_back(8'h00);
        wait_drained();
        set_grid(2, 2, 2);          // small 3D cube
        queue_stream(22);
        wait_drained();
        set_grid(0, 3, 1);          // zero size taken as one, 1D along j
        queue_stream(7);
        wait_drained();
        set_grid(3, 1, 2);          // 2D in the i-k plane, restart mid stream
        req_q.push_back(8'h01); req_q.push_back(8'h00); req_q.push_back(8'hFF);
        req_q.push_back(8'h00);
        wait_drained();
        write_size(CFG_IDX_W'(3), 9'h1FF);  // out-of-range index is dropped
        set_grid(1, 4, 2);
        queue_stream(20);
        wait_drained();
        // largest sizes: saturation, a few records only
        set_grid(511, 256, 300);
        queue_stream(5);
        wait_drained();
        set_grid(256, 256, 1);
        queue_stream(4);
        wait_drained();

        // random grids, mostly small enough to finish
        while (n_req < 1250) begin
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom_range(0, 511); b = $urandom_range(0, 511); c = $urandom_range(0, 511);
                n_rec = $urandom_range(2, 20);
            end else begin
                a = $urandom_range(1, 5); b = $urandom_range(1, 5); c = $urandom_range(1, 4);
                if ($urandom_range(0, 2) == 0) c = 1;
                n_rec = $urandom_range(1, 3 * a * b * c + 10);
            end
            // keep the total close to the planned item count
            if (n_rec > 1260 - n_req) n_rec = 1260 - n_req;
            set_grid(a, b, c);
            if (n_req > 1100) quiet_tail = 1;
            queue_stream(n_rec);
            if ($urandom_range(0, 4) == 0) req_q.push_back(8'h01);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        $display("requests %0d, records checked %0d, streams ended with last %0d",
                 n_req, n_res, n_last);
        $display("grids covered 1D, 2D and 3D shapes with saturated and zero sizes");
        if (errors == 0 && record_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* structured_grid_ngon_connectivity_unit.f */
sv/scgn_pkg.sv
sv/scgn_ctrl.sv
sv/scgn_dp.sv
sv/structured_grid_ngon_connectivity_unit.sv
sim/tb.sv
